FILE: src/elc_pkg.sv
// ----------------------------------------------------------------------------
// elc_pkg
// Shared constants, types and helper functions of the edge-list degree counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package elc_pkg;

  localparam int VERTEX_BITS = 16;
  localparam int ADDR_W      = VERTEX_BITS;
  localparam int ID_W        = VERTEX_BITS + 1;
  localparam int ACC_W       = ID_W + 4;
  localparam int DEPTH_V     = 1 << VERTEX_BITS;
  localparam int DEG_W       = 32;
  localparam int EDGE_W      = 40;
  localparam int MAXV_W      = 16;
  localparam int VIDX_W      = 16;

  localparam logic [ID_W-1:0] VERTEX_LIMIT = {1'b1, {VERTEX_BITS{1'b0}}};

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_NL   = 8'h0A;

  typedef enum logic [2:0] {
    PH_START,
    PH_COMMENT,
    PH_LEAD,
    PH_FIRST,
    PH_BETWEEN,
    PH_SECOND,
    PH_TRAIL,
    PH_BAD
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } bump_req_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_count;
    logic [MAXV_W-1:0] max_vertex;
    logic              edge_added;
    logic              line_dropped;
  } stat_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // acc * 10 + digit, clamped at VERTEX_LIMIT
  function automatic logic [ID_W-1:0] add_digit(input logic [ID_W-1:0] acc,
                                                input logic [7:0] c);
    logic [ACC_W-1:0] v;
    v = (ACC_W'(acc) << 3) + (ACC_W'(acc) << 1) + ACC_W'(c[3:0]);
    if (v > ACC_W'(VERTEX_LIMIT)) begin
      return VERTEX_LIMIT;
    end
    return ID_W'(v);
  endfunction

  function automatic logic [DEG_W-1:0] deg_inc(input logic [DEG_W-1:0] d);
    if (d == '1) begin
      return d;
    end
    return d + DEG_W'(1);
  endfunction

endpackage

FILE: src/elc_if.sv
// ----------------------------------------------------------------------------
// elc_in_if / elc_out_if
// Valid/ready channels for requests into and results out of the degree counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface elc_in_if;
  import elc_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [7:0]        text_byte;
  logic [VIDX_W-1:0] vertex_index;

  modport source (output valid, output opcode, output text_byte, output vertex_index,
                  input ready);
  modport sink   (input valid, input opcode, input text_byte, input vertex_index,
                  output ready);
endinterface

interface elc_out_if;
  import elc_pkg::*;

  logic              valid;
  logic              ready;
  logic [DEG_W-1:0]  degree;
  logic [EDGE_W-1:0] edge_count;
  logic [MAXV_W-1:0] max_vertex;
  logic              edge_added;
  logic              line_dropped;

  modport source (output valid, output degree, output edge_count, output max_vertex,
                  output edge_added, output line_dropped, input ready);
  modport sink   (input valid, input degree, input edge_count, input max_vertex,
                  input edge_added, input line_dropped, output ready);
endinterface

FILE: src/elc_ram.sv
// ----------------------------------------------------------------------------
// elc_ram
// Generic RAM: one write port, two read ports, registered read (old data).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] q_a_r;
  logic [WIDTH-1:0] q_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    q_a_r <= mem_r[rd_addr_a];
    q_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = q_a_r;
  assign rd_data_b = q_b_r;

endmodule

FILE: src/elc_parser.sv
// ----------------------------------------------------------------------------
// elc_parser
// Line parser of the edge-list text; keeps the edge total and largest ID and
// issues degree bump requests at the end of each counted line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elc_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         text_byte,
  output elc_pkg::bump_req_t bump,
  output elc_pkg::stat_t     stat
);
  import elc_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [ID_W-1:0]   first_r, first_nxt;
  logic [ID_W-1:0]   second_r, second_nxt;
  logic [EDGE_W-1:0] edge_r, edge_nxt;
  logic [ADDR_W-1:0] largest_r, largest_nxt;
  logic [ID_W-1:0]   peak;
  logic              is_nl, dig, blk, line_ok, in_range;
  logic              added, dropped;

  assign is_nl    = (text_byte == CH_NL);
  assign dig      = is_digit(text_byte);
  assign blk      = is_blank(text_byte);
  assign line_ok  = (phase_r == PH_SECOND) || (phase_r == PH_TRAIL);
  assign in_range = (first_r < VERTEX_LIMIT) && (second_r < VERTEX_LIMIT);
  assign peak     = (first_r > second_r) ? first_r : second_r;

  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      if (is_nl) begin
        phase_nxt = PH_START;
      end else begin
        case (phase_r)
          PH_START: begin
            if (text_byte == CH_HASH) phase_nxt = PH_COMMENT;
            else if (blk)             phase_nxt = PH_LEAD;
            else if (dig)             phase_nxt = PH_FIRST;
            else                      phase_nxt = PH_BAD;
          end
          PH_LEAD: begin
            if (dig)       phase_nxt = PH_FIRST;
            else if (!blk) phase_nxt = PH_BAD;
          end
          PH_FIRST: begin
            if (blk)       phase_nxt = PH_BETWEEN;
            else if (!dig) phase_nxt = PH_BAD;
          end
          PH_BETWEEN: begin
            if (dig)       phase_nxt = PH_SECOND;
            else if (!blk) phase_nxt = PH_BAD;
          end
          PH_SECOND: begin
            if (!dig) phase_nxt = PH_TRAIL;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    first_nxt   = first_r;
    second_nxt  = second_r;
    edge_nxt    = edge_r;
    largest_nxt = largest_r;
    added       = 1'b0;
    dropped     = 1'b0;
    if (step) begin
      if (is_nl) begin
        if (line_ok) begin
          if (!in_range) begin
            dropped = 1'b1;
          end else begin
            if (ADDR_W'(peak) > largest_r) largest_nxt = ADDR_W'(peak);
            if (first_r != second_r) begin
              if (edge_r != '1) edge_nxt = edge_r + EDGE_W'(1);
              added = 1'b1;
            end
          end
        end else if (phase_r != PH_COMMENT) begin
          dropped = 1'b1;
        end
        first_nxt  = '0;
        second_nxt = '0;
      end else begin
        case (phase_r)
          PH_START, PH_LEAD: begin
            if (dig) first_nxt = add_digit('0, text_byte);
          end
          PH_FIRST: begin
            if (dig) first_nxt = add_digit(first_r, text_byte);
          end
          PH_BETWEEN: begin
            if (dig) second_nxt = add_digit('0, text_byte);
          end
          PH_SECOND: begin
            if (dig) second_nxt = add_digit(second_r, text_byte);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      first_r   <= '0;
      second_r  <= '0;
      edge_r    <= '0;
      largest_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      edge_r    <= edge_nxt;
      largest_r <= largest_nxt;
    end
  end

  assign bump.valid  = added;
  assign bump.addr_a = first_r[ADDR_W-1:0];
  assign bump.addr_b = second_r[ADDR_W-1:0];

  assign stat.edge_count   = edge_nxt;
  assign stat.max_vertex   = MAXV_W'(largest_nxt);
  assign stat.edge_added   = added;
  assign stat.line_dropped = dropped;

endmodule

FILE: src/elc_degree.sv
// ----------------------------------------------------------------------------
// elc_degree
// Degree store: clearing pass after reset, read-modify-write of two vertices
// per counted edge, and forwarded degree reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elc_degree (
  input  logic                       clk,
  input  logic                       rst_n,
  input  elc_pkg::bump_req_t         bump,
  input  logic [elc_pkg::ADDR_W-1:0] rd_addr,
  output logic [elc_pkg::DEG_W-1:0]  rd_data,
  output logic                       busy
);
  import elc_pkg::*;

  logic              clr_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              bmp1_v_r;
  logic [ADDR_W-1:0] bmp1_a_r, bmp1_b_r;
  logic              wb_v_r;
  logic              ent_a_v_r, ent_b_v_r;
  logic [ADDR_W-1:0] ent_a_addr_r, ent_b_addr_r;
  logic [DEG_W-1:0]  ent_a_val_r, ent_b_val_r;
  logic [ADDR_W-1:0] rd_addr_q_r;

  logic [ADDR_W-1:0] port_a_addr;
  logic [DEG_W-1:0]  q_a, q_b, new_a, new_b;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DEG_W-1:0]  wr_data;

  assign port_a_addr = bump.valid ? bump.addr_a : rd_addr;
  assign new_a       = deg_inc(q_a);
  assign new_b       = deg_inc(q_b);

  // first vertex written in the cycle after its read, second in the cycle after that
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = bmp1_a_r;
    wr_data = new_a;
    if (clr_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (bmp1_v_r) begin
      wr_en   = 1'b1;
    end else if (wb_v_r) begin
      wr_en   = 1'b1;
      wr_addr = ent_b_addr_r;
      wr_data = ent_b_val_r;
    end
  end

  elc_ram #(
    .WIDTH (DEG_W),
    .DEPTH (DEPTH_V)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (port_a_addr),
    .rd_addr_b (bump.addr_b),
    .rd_data_a (q_a),
    .rd_data_b (q_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      bmp1_v_r   <= 1'b0;
      wb_v_r     <= 1'b0;
      ent_a_v_r  <= 1'b0;
      ent_b_v_r  <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == '1) clr_r <= 1'b0;
      end
      bmp1_v_r <= bump.valid;
      wb_v_r   <= bmp1_v_r;
      if (bmp1_v_r) begin
        ent_a_v_r <= 1'b1;
        ent_b_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q_r <= port_a_addr;
    if (bump.valid) begin
      bmp1_a_r <= bump.addr_a;
      bmp1_b_r <= bump.addr_b;
    end
    if (bmp1_v_r) begin
      ent_a_addr_r <= bmp1_a_r;
      ent_a_val_r  <= new_a;
      ent_b_addr_r <= bmp1_b_r;
      ent_b_val_r  <= new_b;
    end
  end

  // latest bumped values cover writes still in flight at read time
  always_comb begin
    rd_data = q_a;
    if (ent_b_v_r && (ent_b_addr_r == rd_addr_q_r)) begin
      rd_data = ent_b_val_r;
    end else if (ent_a_v_r && (ent_a_addr_r == rd_addr_q_r)) begin
      rd_data = ent_a_val_r;
    end
  end

  assign busy = clr_r;

endmodule

FILE: src/edge_list_degree_counter_core.sv
// ----------------------------------------------------------------------------
// edge_list_degree_counter_core
// Vertex degree histogram of an edge-list text stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one request per cycle while in_ch.ready is high: opcode
//   OP_BYTE feeds the next text byte, opcode OP_READ asks for the degree of
//   vertex_index. out_ch returns exactly one result per request, in order,
//   with the edge total and the largest vertex ID after that request.
//   Path: each result passes the read stage and then the output register
//   before it is valid on out_ch.
//   Throughput: one request per cycle while in_ch.ready is high; each counted
//   line reads both vertices at its newline and writes them back one after
//   the other, whatever the input does; reads issued meanwhile are forwarded.
//   Reset: a clearing pass writes zero to all 2^VERTEX_BITS (65536) degree
//   entries, one per cycle; in_ch.ready stays low for those cycles.
//   Stall: a result waits in the output register while one more request is
//   held in the read stage; in_ch.ready then drops until out_ch.ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_list_degree_counter_core (
  input logic       clk,
  input logic       rst_n,
  elc_in_if.sink    in_ch,
  elc_out_if.source out_ch
);
  import elc_pkg::*;

  bump_req_t        bump;
  stat_t            stat;
  logic [DEG_W-1:0] rd_data;
  logic             busy;
  logic             in_acc, byte_step, out_free, s1_adv;

  logic             s1_v_r, s1_rd_r, s1_fresh_r;
  stat_t            s1_stat_r;
  logic [DEG_W-1:0] s1_deg_r, deg_now;
  logic             out_v_r;
  logic [DEG_W-1:0] out_deg_r;
  stat_t            out_stat_r;

  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_adv      = s1_v_r && out_free;
  assign in_ch.ready = !busy && (!s1_v_r || out_free);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign byte_step   = in_acc && (in_ch.opcode == OP_BYTE);

  elc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (byte_step),
    .text_byte (in_ch.text_byte),
    .bump      (bump),
    .stat      (stat)
  );

  elc_degree u_degree (
    .clk     (clk),
    .rst_n   (rst_n),
    .bump    (bump),
    .rd_addr (ADDR_W'(in_ch.vertex_index)),
    .rd_data (rd_data),
    .busy    (busy)
  );

  assign deg_now = s1_fresh_r ? rd_data : s1_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s1_fresh_r <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      s1_fresh_r <= in_acc;
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (out_free) out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rd_r   <= (in_ch.opcode == OP_READ);
      s1_stat_r <= stat;
    end
    if (s1_fresh_r) s1_deg_r <= rd_data;
    if (s1_adv) begin
      out_deg_r  <= s1_rd_r ? deg_now : '0;
      out_stat_r <= s1_stat_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.degree       = out_deg_r;
  assign out_ch.edge_count   = out_stat_r.edge_count;
  assign out_ch.max_vertex   = out_stat_r.max_vertex;
  assign out_ch.edge_added   = out_stat_r.edge_added;
  assign out_ch.line_dropped = out_stat_r.line_dropped;

endmodule

FILE: src/elc_checker.sv
// ----------------------------------------------------------------------------
// elc_checker
// Port-level checks of the degree counter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [elc_pkg::DEG_W-1:0]  out_degree,
  input logic [elc_pkg::EDGE_W-1:0] out_edge_count,
  input logic                       out_edge_added,
  input logic                       out_line_dropped
);
  import elc_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_edge_count) && $stable(out_degree))
    else $error("stalled result changed");

  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during clearing pass");

  a_no_early_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_acc)
    else $error("result or request right after reset");

  a_byte_degree_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_edge_added || out_line_dropped) |-> out_degree == '0)
    else $error("byte result carries a degree");

endmodule

bind edge_list_degree_counter_core elc_checker u_elc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_degree       (out_ch.degree),
  .out_edge_count   (out_ch.edge_count),
  .out_edge_added   (out_ch.edge_added),
  .out_line_dropped (out_ch.line_dropped)
);
